### design/heap_topk_selector_top_defines.svh
// Assertion macros shared by the heap top-k selector RTL.
// No dependencies; expects clk and rst_n in the including scope.
`ifndef HEAP_TOPK_SELECTOR_TOP_DEFINES_SVH
`define HEAP_TOPK_SELECTOR_TOP_DEFINES_SVH

// condition holds at every edge out of reset
`define HTK_ASSERT_HOLDS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define HTK_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HTK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/htk_pkg.sv
// Package for the heap top-k selector: types, constants, ordering functions.
// No dependencies.
package htk_pkg;

    localparam int MAX_K_DEF = 64;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_SMALLEST = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_IS_HALF = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_GIVEN_IDS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_OFFSET  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_K_USED        = 3'd4;

    localparam logic [31:0] ID_NONE = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        keep_smallest;
        logic        value_is_half;
        logic        use_given_ids;
        logic [31:0] index_offset;
        logic [6:0]  k_used;
    } cfg_t;

    typedef struct packed {
        logic [31:0] value;
        logic [31:0] id;
        logic        final_item;
    } item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK,
        S_SRD,
        S_SCMP,
        S_PRD,
        S_PGET,
        S_ERD,
        S_EOUT,
        S_INIT
    } htk_state_t;

    function automatic logic signed [32:0] sort_key(input logic [31:0] v, input logic half);
        logic signed [32:0] m;
        begin
            if (half)
            begin
                m = {18'd0, v[14:0]};
                sort_key = v[15] ? -m : m;
            end
            else
            begin
                sort_key = {v[31], v};
            end
        end
    endfunction

    // a strictly worse than b
    function automatic logic worse(input logic [31:0] av, input logic aok,
                                   input logic [31:0] bv, input logic bok,
                                   input logic smallest, input logic half);
        logic signed [32:0] ka;
        logic signed [32:0] kb;
        begin
            ka = sort_key(av, half);
            kb = sort_key(bv, half);
            if (!aok)
                worse = bok;
            else if (!bok)
                worse = 1'b0;
            else
                worse = smallest ? (ka > kb) : (ka < kb);
        end
    endfunction

    function automatic logic [31:0] sentinel(input logic smallest, input logic half);
        begin
            if (half)
                sentinel = smallest ? 32'h0000_7BFF : 32'h0000_FBFF;
            else
                sentinel = smallest ? 32'h7FFF_FFFF : 32'h8000_0000;
        end
    endfunction

endpackage

### design/htk_if.sv
// Stream interfaces for the heap top-k selector: input words and result words.
// No dependencies.
interface htk_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] dist_value;
    logic [31:0]        given_id;
    logic               final_item;
    modport source (output valid, dist_value, given_id, final_item, input ready);
    modport sink (input valid, dist_value, given_id, final_item, output ready);
endinterface

interface htk_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_value;
    logic [31:0]        out_id;
    logic               slot_valid;
    logic               run_end;
    modport source (output valid, out_value, out_id, slot_valid, run_end, input ready);
    modport sink (input valid, out_value, out_id, slot_valid, run_end, output ready);
endinterface

### design/htk_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module htk_ram #(
    parameter int W = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [W-1:0]                           wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [W-1:0]                           rdata
);
    logic [W-1:0] mem_reg [DEPTH];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

### design/htk_front.sv
// Front end: accepts input words, forms the id and masks the value.
// Depends on htk_pkg and htk_in_if.
module htk_front (
    input  logic           clk,
    input  logic           rst_n,
    input  htk_pkg::cfg_t  cfg,
    htk_in_if.sink         din,
    input  logic           q_full,
    output logic           q_push,
    output htk_pkg::item_t q_item
);
    import htk_pkg::*;

    logic [31:0] pos_reg;
    logic [31:0] pos_next;

    assign din.ready = !q_full;
    assign q_push = din.valid && !q_full;

    always_comb
    begin
        q_item.value = cfg.value_is_half ? {16'd0, din.dist_value[15:0]} : din.dist_value;
        q_item.id = cfg.use_given_ids ? din.given_id : (cfg.index_offset + pos_reg);
        q_item.final_item = din.final_item;
        pos_next = pos_reg;
        if (q_push)
            pos_next = din.final_item ? 32'd0 : (pos_reg + 32'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else
            pos_reg <= pos_next;
    end
endmodule

### design/htk_fifo.sv
// Two-entry queue between the front end and the heap engine.
// Depends on htk_pkg.
module htk_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  htk_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           nonempty,
    output htk_pkg::item_t pop_item
);
    import htk_pkg::*;

    item_t       ent_reg [2];
    logic        head_reg;
    logic        head_next;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic        tail;

    assign full = cnt_reg == 2'd2;
    assign nonempty = cnt_reg != 2'd0;
    assign pop_item = ent_reg[head_reg];
    assign tail = head_reg ^ cnt_reg[0];

    always_comb
    begin
        head_next = pop ? ~head_reg : head_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[tail] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule

### design/htk_engine.sv
// Heap engine: root check, sift-down, final pop and best-first emission.
// Depends on htk_pkg, htk_ram, htk_out_if and the assertion macros.
`include "heap_topk_selector_top_defines.svh"
module htk_engine #(
    parameter int MAX_K = htk_pkg::MAX_K_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  htk_pkg::cfg_t  cfg,
    input  logic           q_nonempty,
    input  htk_pkg::item_t q_item,
    output logic           q_pop,
    htk_out_if.source      dout
);
    import htk_pkg::*;

    localparam int AW = MAX_K > 1 ? $clog2(MAX_K) : 1;
    localparam int KW = $clog2(MAX_K + 1);

    htk_state_t  state_reg;
    htk_state_t  state_next;

    logic [31:0] cur_val_reg, cur_val_next;
    logic [31:0] cur_id_reg, cur_id_next;
    logic        cur_ok_reg, cur_ok_next;
    logic        fin_reg, fin_next;
    logic [AW-1:0] i_reg, i_next;
    logic [KW-1:0] n_reg, n_next;
    logic [KW-1:0] nv_reg, nv_next;
    logic [KW-1:0] t_reg, t_next;

    logic        ovalid_reg, ovalid_next;
    logic [31:0] oval_reg, oval_next;
    logic [31:0] oid_reg, oid_next;
    logic        oslot_reg, oslot_next;
    logic        oend_reg, oend_next;

    logic [AW-1:0] raddr_a, raddr_b, hwaddr, pwaddr, praddr;
    logic [64:0]   rdata_a, rdata_b, hwdata;
    logic [63:0]   pwdata, pdata;
    logic          hwe, pwe;

    logic [31:0] k32, kc32, l32, r32, n32, pidx32;
    logic [KW-1:0] k_eff;
    logic [AW-1:0] l_idx, r_idx, c_idx, last_idx;
    logic [31:0] a_val, b_val, c_val, c_id;
    logic        a_ok, b_ok;
    logic        c_ok, c_is_r, down, root_take, leaf, out_free, sift_done;
    logic [31:0] sent;

    always_comb
    begin
        k32 = {25'd0, cfg.k_used};
        if (k32 == 32'd0)
            kc32 = 32'd1;
        else if (k32 > 32'(MAX_K))
            kc32 = 32'(MAX_K);
        else
            kc32 = k32;
        k_eff = kc32[KW-1:0];
    end

    // heap word: {slot valid, id, value}
    htk_ram #(.W(65), .DEPTH(MAX_K)) u_heap_a (
        .clk(clk), .we(hwe), .waddr(hwaddr), .wdata(hwdata), .raddr(raddr_a), .rdata(rdata_a)
    );
    htk_ram #(.W(65), .DEPTH(MAX_K)) u_heap_b (
        .clk(clk), .we(hwe), .waddr(hwaddr), .wdata(hwdata), .raddr(raddr_b), .rdata(rdata_b)
    );
    htk_ram #(.W(64), .DEPTH(MAX_K)) u_popbuf (
        .clk(clk), .we(pwe), .waddr(pwaddr), .wdata(pwdata), .raddr(praddr), .rdata(pdata)
    );

    always_comb
    begin
        a_val = rdata_a[31:0];
        b_val = rdata_b[31:0];
        a_ok = rdata_a[64];
        b_ok = rdata_b[64];
        l32 = {{(31 - AW){1'b0}}, i_reg, 1'b1};
        r32 = l32 + 32'd1;
        n32 = 32'(n_reg);
        l_idx = l32[AW-1:0];
        r_idx = r32[AW-1:0];
        leaf = l32 >= n32;
        c_is_r = (r32 < n32) && worse(b_val, b_ok, a_val, a_ok,
                                      cfg.keep_smallest, cfg.value_is_half);
        c_idx = c_is_r ? r_idx : l_idx;
        c_val = c_is_r ? b_val : a_val;
        c_id = c_is_r ? rdata_b[63:32] : rdata_a[63:32];
        c_ok = c_is_r ? b_ok : a_ok;
        down = worse(c_val, c_ok, cur_val_reg, cur_ok_reg, cfg.keep_smallest,
                     cfg.value_is_half);
        root_take = worse(a_val, a_ok, cur_val_reg, 1'b1, cfg.keep_smallest,
                          cfg.value_is_half);
        last_idx = 32'(n_reg - 1'b1) > 32'd0 ? AW'(n_reg - 1'b1) : '0;
        pidx32 = 32'(nv_reg) - 32'(t_reg) - 32'd1;
        out_free = !ovalid_reg || dout.ready;
        sent = sentinel(cfg.keep_smallest, cfg.value_is_half);
        sift_done = (state_reg == S_SRD && leaf) || (state_reg == S_SCMP && !down);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT: if (32'(i_reg) == 32'(MAX_K - 1)) state_next = S_IDLE;
            S_IDLE: if (q_nonempty) state_next = S_CHK;
            S_CHK:
            begin
                if (root_take)
                    state_next = S_SRD;
                else
                    state_next = fin_reg ? S_PRD : S_IDLE;
            end
            S_SRD:  state_next = leaf ? (fin_reg ? S_PRD : S_IDLE) : S_SCMP;
            S_SCMP: state_next = down ? S_SRD : (fin_reg ? S_PRD : S_IDLE);
            S_PRD:  state_next = (n_reg == '0) ? S_ERD : S_PGET;
            S_PGET: state_next = S_SRD;
            S_ERD:  state_next = S_EOUT;
            S_EOUT:
            begin
                if (out_free)
                    state_next = (32'(t_reg) + 32'd1 == 32'(k_eff)) ? S_IDLE : S_ERD;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cur_val_next = cur_val_reg;
        cur_id_next = cur_id_reg;
        cur_ok_next = cur_ok_reg;
        fin_next = fin_reg;
        i_next = i_reg;
        n_next = n_reg;
        nv_next = nv_reg;
        t_next = t_reg;
        q_pop = 1'b0;
        raddr_a = '0;
        raddr_b = last_idx;
        hwe = 1'b0;
        hwaddr = i_reg;
        hwdata = {cur_ok_reg, cur_id_reg, cur_val_reg};
        pwe = 1'b0;
        pwaddr = nv_reg[AW-1:0];
        pwdata = rdata_a[63:0];
        praddr = pidx32[AW-1:0];
        ovalid_next = dout.ready ? 1'b0 : ovalid_reg;
        oval_next = oval_reg;
        oid_next = oid_reg;
        oslot_next = oslot_reg;
        oend_next = oend_reg;

        unique case (state_reg)
            S_INIT:
            begin
                // clearing pass: every slot marked empty
                hwe = 1'b1;
                hwdata = '0;
                i_next = i_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (q_nonempty)
                begin
                    q_pop = 1'b1;
                    cur_val_next = q_item.value;
                    cur_id_next = q_item.id;
                    cur_ok_next = 1'b1;
                    fin_next = q_item.final_item;
                    i_next = '0;
                    n_next = k_eff;
                    nv_next = '0;
                end
            end
            S_SRD:
            begin
                raddr_a = l_idx;
                raddr_b = r_idx;
                if (leaf)
                    hwe = 1'b1;
            end
            S_SCMP:
            begin
                hwe = 1'b1;
                if (down)
                begin
                    hwdata = {c_ok, c_id, c_val};
                    i_next = c_idx;
                end
            end
            S_PRD:
            begin
                t_next = '0;
            end
            S_PGET:
            begin
                if (a_ok)
                begin
                    pwe = 1'b1;
                    nv_next = nv_reg + 1'b1;
                end
                // the slot leaving the heap is emptied; the last pop empties the root
                hwe = 1'b1;
                hwaddr = last_idx;
                hwdata = '0;
                cur_val_next = b_val;
                cur_id_next = rdata_b[63:32];
                cur_ok_next = (n_reg == KW'(1)) ? 1'b0 : b_ok;
                n_next = n_reg - 1'b1;
                i_next = '0;
            end
            S_EOUT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    if (t_reg < nv_reg)
                    begin
                        oval_next = pdata[31:0];
                        oid_next = pdata[63:32];
                        oslot_next = 1'b1;
                    end
                    else
                    begin
                        oval_next = sent;
                        oid_next = ID_NONE;
                        oslot_next = 1'b0;
                    end
                    oend_next = 32'(t_reg) + 32'd1 == 32'(k_eff);
                    t_next = t_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            fin_reg <= 1'b0;
            i_reg <= '0;
            n_reg <= '0;
            nv_reg <= '0;
            t_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fin_reg <= fin_next;
            i_reg <= i_next;
            n_reg <= n_next;
            nv_reg <= nv_next;
            t_reg <= t_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_val_reg <= cur_val_next;
        cur_id_reg <= cur_id_next;
        cur_ok_reg <= cur_ok_next;
        oval_reg <= oval_next;
        oid_reg <= oid_next;
        oslot_reg <= oslot_next;
        oend_reg <= oend_next;
    end

    assign dout.valid = ovalid_reg;
    assign dout.out_value = oval_reg;
    assign dout.out_id = oid_reg;
    assign dout.slot_valid = oslot_reg;
    assign dout.run_end = oend_reg;

    `HTK_ASSERT_HOLDS(a_nv_le_k, 32'(nv_reg) <= 32'(MAX_K), "more popped words than k")
    `HTK_ASSERT_IMPL(a_sift_in_heap, state_reg == S_SCMP, 32'(i_reg) < 32'(n_reg), "sift outside heap")
    `HTK_ASSERT_NEXT(a_run_end_word, state_reg == S_EOUT && out_free && oend_next, state_reg == S_IDLE && dout.valid && dout.run_end, "run end word lost")
    `HTK_ASSERT_IMPL(a_sift_done_state, sift_done && !fin_reg, state_next == S_IDLE, "sift end lost")
endmodule

### design/heap_topk_selector_top.sv
// Heap top-k selector: a word passes through the queue to the engine; a dropped word
// takes the root check only, a kept one replaces the root and sifts down level by level.
// A final word then pops all k slots, each with such a sift, and emits the result words.
// Throughput is set by the single sift-down engine and its RAM ports.
// Reset: control registers take their reset values, then a clearing pass empties the heap.
// Depends on htk_pkg, htk_if, htk_front, htk_fifo, htk_engine.
module heap_topk_selector_top #(
    parameter int MAX_K = htk_pkg::MAX_K_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [htk_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [htk_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    htk_in_if.sink                            din,
    htk_out_if.source                         dout
);
    import htk_pkg::*;

    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    logic  q_full, q_push, q_pop, q_nonempty;
    item_t q_in, q_out;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KEEP_SMALLEST: cfg_next.keep_smallest = cfg_wdata[0];
                CFG_VALUE_IS_HALF: cfg_next.value_is_half = cfg_wdata[0];
                CFG_USE_GIVEN_IDS: cfg_next.use_given_ids = cfg_wdata[0];
                CFG_INDEX_OFFSET:  cfg_next.index_offset = cfg_wdata;
                CFG_K_USED:        cfg_next.k_used = cfg_wdata[6:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.keep_smallest <= 1'b1;
            cfg_reg.value_is_half <= 1'b0;
            cfg_reg.use_given_ids <= 1'b1;
            cfg_reg.index_offset <= '0;
            cfg_reg.k_used <= 7'd64;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    htk_front u_front (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg), .din(din),
        .q_full(q_full), .q_push(q_push), .q_item(q_in)
    );

    htk_fifo u_fifo (
        .clk(clk), .rst_n(rst_n), .push(q_push), .push_item(q_in), .full(q_full),
        .pop(q_pop), .nonempty(q_nonempty), .pop_item(q_out)
    );

    htk_engine #(.MAX_K(MAX_K)) u_engine (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg), .q_nonempty(q_nonempty),
        .q_item(q_out), .q_pop(q_pop), .dout(dout)
    );
endmodule
